[sv/mcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markov chain sampler package
// Shared widths, codes and state types for the symbol sampler.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int MAX_SYMBOLS = 10;
  localparam int TABLE_ROWS  = MAX_SYMBOLS + 1;
  localparam int INIT_ROW    = MAX_SYMBOLS;
  localparam int TBL_DEPTH   = TABLE_ROWS * MAX_SYMBOLS;
  localparam int TBL_AW      = $clog2(TBL_DEPTH);
  localparam int SYM_W       = 4;
  localparam int PROB_W      = 17;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = PROB_W + SYM_W + 1;
  localparam int CNT_AW      = $clog2(MAX_SYMBOLS);

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_RESTART  = 2'd1,
    ACT_GENERATE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    TOP_IDLE,
    TOP_FETCH,
    TOP_WAIT,
    TOP_SORT,
    TOP_FINISH
  } top_state_e;

  typedef enum logic [1:0] {
    SRT_IDLE,
    SRT_LOAD,
    SRT_CMP
  } sort_state_e;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [SYM_W-1:0] symbol;
  } sort_status_t;

endpackage

[sv/mcs_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampler input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface mcs_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [3:0]                 table_row;
  logic [3:0]                 table_column;
  logic [mcs_pkg::PROB_W-1:0] probability;
  logic [mcs_pkg::PROB_W-1:0] random_draw;

  modport source (output valid, action, table_row, table_column, probability, random_draw,
                  input ready);
  modport sink (input valid, action, table_row, table_column, probability, random_draw,
                output ready);
endinterface

[sv/mcs_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampler output channel
// Valid/ready channel carrying one sampled result.
// ----------------------------------------------------------------------------
interface mcs_out_if;
  logic                      valid;
  logic                      ready;
  logic [mcs_pkg::SYM_W-1:0] symbol;
  logic                      no_selection;
  logic [mcs_pkg::CNT_W-1:0] occupancy;

  modport source (output valid, symbol, no_selection, occupancy, input ready);
  modport sink (input valid, symbol, no_selection, occupancy, output ready);
endinterface

[sv/mcs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mcs_sort_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort and scan unit
// Exchange sort of one row, one compare per cycle, with the cumulative scan
// folded into the end of each pass.
// ----------------------------------------------------------------------------
module mcs_sort_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_en_i,
  input  logic [mcs_pkg::SYM_W-1:0]  load_idx_i,
  input  logic [mcs_pkg::PROB_W-1:0] load_val_i,
  input  logic                       start_i,
  input  logic [mcs_pkg::SYM_W-1:0]  count_i,
  input  logic [mcs_pkg::PROB_W-1:0] draw_i,
  output mcs_pkg::sort_status_t      status_o
);

  mcs_pkg::sort_state_e state_q, state_d;

  logic [mcs_pkg::PROB_W-1:0] vals_q [mcs_pkg::MAX_SYMBOLS];
  logic [mcs_pkg::SYM_W-1:0]  ids_q  [mcs_pkg::MAX_SYMBOLS];
  logic [mcs_pkg::SYM_W-1:0]  i_q, j_q;
  logic [mcs_pkg::PROB_W-1:0] cur_val_q;
  logic [mcs_pkg::SYM_W-1:0]  cur_id_q;
  logic [mcs_pkg::SUM_W-1:0]  sum_q;
  mcs_pkg::sort_status_t      status_q;

  logic [mcs_pkg::SYM_W-1:0]  rd_idx;
  logic [mcs_pkg::PROB_W-1:0] rd_val;
  logic [mcs_pkg::SYM_W-1:0]  rd_id;
  logic                       pass_end;
  logic [mcs_pkg::SUM_W-1:0]  hi_sum;
  logic                       in_interval;
  logic                       last_pass;
  logic                       do_swap;

  assign rd_idx      = (state_q == mcs_pkg::SRT_LOAD) ? i_q : j_q;
  assign rd_val      = vals_q[rd_idx];
  assign rd_id       = ids_q[rd_idx];
  assign pass_end    = (j_q >= count_i);
  assign hi_sum      = sum_q + mcs_pkg::SUM_W'(cur_val_q);
  assign in_interval = (mcs_pkg::SUM_W'(draw_i) >= sum_q) &&
                       (mcs_pkg::SUM_W'(draw_i) <= hi_sum);
  assign last_pass   = ((i_q + 1'b1) == count_i);
  assign do_swap     = (state_q == mcs_pkg::SRT_CMP) && !pass_end && (rd_val < cur_val_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcs_pkg::SRT_IDLE: begin
        if (start_i && (count_i != '0)) begin
          state_d = mcs_pkg::SRT_LOAD;
        end
      end
      mcs_pkg::SRT_LOAD: begin
        state_d = mcs_pkg::SRT_CMP;
      end
      mcs_pkg::SRT_CMP: begin
        if (pass_end) begin
          if (in_interval || last_pass) begin
            state_d = mcs_pkg::SRT_IDLE;
          end else begin
            state_d = mcs_pkg::SRT_LOAD;
          end
        end
      end
      default: state_d = mcs_pkg::SRT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mcs_pkg::SRT_IDLE;
      status_q <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == mcs_pkg::SRT_IDLE) && start_i && (count_i == '0)) begin
        // An empty alphabet scans nothing.
        status_q.done <= 1'b1;
        status_q.hit  <= 1'b0;
      end else if ((state_q == mcs_pkg::SRT_CMP) && pass_end &&
                   (in_interval || last_pass)) begin
        status_q.done   <= 1'b1;
        status_q.hit    <= in_interval;
        status_q.symbol <= cur_id_q;
      end else begin
        status_q.done <= 1'b0;
      end
    end
  end

  // Datapath: row registers, pass indices and running sum.
  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      vals_q[load_idx_i] <= load_val_i;
      ids_q[load_idx_i]  <= load_idx_i;
    end
    if (start_i) begin
      i_q   <= '0;
      sum_q <= '0;
    end
    if (state_q == mcs_pkg::SRT_LOAD) begin
      cur_val_q <= rd_val;
      cur_id_q  <= rd_id;
      j_q       <= i_q + 1'b1;
    end
    if (do_swap) begin
      vals_q[rd_idx] <= cur_val_q;
      ids_q[rd_idx]  <= cur_id_q;
      cur_val_q      <= rd_val;
      cur_id_q       <= rd_id;
    end
    if ((state_q == mcs_pkg::SRT_CMP) && !pass_end) begin
      j_q <= j_q + 1'b1;
    end
    if ((state_q == mcs_pkg::SRT_CMP) && pass_end && !in_interval) begin
      sum_q <= hi_sum;
      i_q   <= i_q + 1'b1;
    end
  end

  assign status_o = status_q;

endmodule

[sv/markov_chain_symbol_sampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markov chain symbol sampler
// Inverse-CDF draw over a sorted row of a probability table held in RAM,
// with per-symbol occupancy counters held in a second RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Content
//  in_i      sink       action, table_row, table_column, probability, random_draw
//  out_o     source     symbol, no_selection, occupancy (one per generate)
//  cfg       write      cfg_wdata_i = alphabet_size, taken when cfg_we_i is high
//
// Write, restart and unused actions leave the sampler idle and ready for the
// next item. A generate holds off the input until it is done, and ends
// sooner when the scan hits before the last pass; the exchange sort does one
// compare per cycle on the row registers.
// There is no clearing pass after reset: counters carry one valid bit each.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and a later generate holds in its last step until it is free.
//
module markov_chain_symbol_sampler (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  mcs_in_if.sink     in_i,
  mcs_out_if.source  out_o
);

  mcs_pkg::top_state_e state_q, state_d;

  // Configuration: alphabet size, clamped to the table width when used.
  logic [mcs_pkg::SYM_W-1:0] alpha_q;
  logic [mcs_pkg::SYM_W-1:0] n_sym;

  // Chain state.
  logic [mcs_pkg::SYM_W-1:0]       last_q;
  logic                            started_q;
  logic [mcs_pkg::MAX_SYMBOLS-1:0] cnt_vld_q;

  // Per-item registers.
  logic [mcs_pkg::SYM_W-1:0]  row_q;
  logic [mcs_pkg::SYM_W-1:0]  n_q;
  logic [mcs_pkg::PROB_W-1:0] draw_q;
  logic [mcs_pkg::SYM_W-1:0]  col_q;
  logic                       rd_pend_q;
  logic [mcs_pkg::SYM_W-1:0]  rd_col_q;
  logic                       hit_q;
  logic [mcs_pkg::SYM_W-1:0]  sym_q;

  // Output register.
  logic                      out_valid_q;
  logic [mcs_pkg::SYM_W-1:0] out_sym_q;
  logic                      out_nosel_q;
  logic [mcs_pkg::CNT_W-1:0] out_occ_q;

  logic                       in_xfer;
  mcs_pkg::action_e           act;
  logic                       tbl_we;
  logic [mcs_pkg::TBL_AW-1:0] tbl_waddr;
  logic [mcs_pkg::TBL_AW-1:0] tbl_raddr;
  logic [mcs_pkg::PROB_W-1:0] tbl_rdata;
  logic                       tbl_re;
  logic                       write_ok;

  logic                       cnt_re;
  logic                       cnt_we;
  logic [mcs_pkg::CNT_W-1:0]  cnt_rdata;
  logic [mcs_pkg::CNT_W-1:0]  cnt_old;
  logic [mcs_pkg::CNT_W-1:0]  cnt_new;

  logic                       sort_start;
  mcs_pkg::sort_status_t      sort_status;
  logic                       out_free;
  logic                       finish;

  assign n_sym    = (alpha_q > mcs_pkg::SYM_W'(mcs_pkg::MAX_SYMBOLS)) ?
                    mcs_pkg::SYM_W'(mcs_pkg::MAX_SYMBOLS) : alpha_q;
  assign act      = mcs_pkg::action_e'(in_i.action);
  assign in_i.ready = (state_q == mcs_pkg::TOP_IDLE);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign finish   = (state_q == mcs_pkg::TOP_FINISH) && out_free;

  // Table writes land straight in the RAM in the cycle of the transfer.
  // Rows beyond the initial row and columns beyond the table width are dropped.
  assign write_ok  = (in_i.table_row <= mcs_pkg::SYM_W'(mcs_pkg::INIT_ROW)) &&
                     (in_i.table_column < mcs_pkg::SYM_W'(mcs_pkg::MAX_SYMBOLS));
  assign tbl_we    = in_xfer && (act == mcs_pkg::ACT_WRITE) && write_ok;
  assign tbl_waddr = mcs_pkg::TBL_AW'(in_i.table_row) * mcs_pkg::TBL_AW'(mcs_pkg::MAX_SYMBOLS)
                   + mcs_pkg::TBL_AW'(in_i.table_column);
  assign tbl_re    = (state_q == mcs_pkg::TOP_FETCH);
  assign tbl_raddr = mcs_pkg::TBL_AW'(row_q) * mcs_pkg::TBL_AW'(mcs_pkg::MAX_SYMBOLS)
                   + mcs_pkg::TBL_AW'(col_q);

  mcs_ram #(
    .WIDTH (mcs_pkg::PROB_W),
    .DEPTH (mcs_pkg::TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (in_i.probability),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Occupancy counters: read when the sort reports a hit, then incremented
  // with saturation and written back once the output register is free.
  // An entry whose valid bit is clear reads as zero.
  assign cnt_re  = sort_status.done && sort_status.hit;
  assign cnt_we  = finish && hit_q;
  assign cnt_old = cnt_vld_q[sym_q] ? cnt_rdata : '0;
  assign cnt_new = (&cnt_old) ? cnt_old : cnt_old + 1'b1;

  mcs_ram #(
    .WIDTH (mcs_pkg::CNT_W),
    .DEPTH (mcs_pkg::MAX_SYMBOLS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (mcs_pkg::CNT_AW'(sym_q)),
    .wdata_i (cnt_new),
    .re_i    (cnt_re),
    .raddr_i (mcs_pkg::CNT_AW'(sort_status.symbol)),
    .rdata_o (cnt_rdata)
  );

  assign sort_start = (state_q == mcs_pkg::TOP_WAIT);

  mcs_sort_scan u_sort_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_en_i  (rd_pend_q),
    .load_idx_i (rd_col_q),
    .load_val_i (tbl_rdata),
    .start_i    (sort_start),
    .count_i    (n_q),
    .draw_i     (draw_q),
    .status_o   (sort_status)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcs_pkg::TOP_IDLE: begin
        if (in_xfer && (act == mcs_pkg::ACT_GENERATE)) begin
          // With no symbols in use there is nothing to fetch.
          state_d = (n_sym == '0) ? mcs_pkg::TOP_WAIT : mcs_pkg::TOP_FETCH;
        end
      end
      mcs_pkg::TOP_FETCH: begin
        if ((col_q + 1'b1) == n_q) begin
          state_d = mcs_pkg::TOP_WAIT;
        end
      end
      mcs_pkg::TOP_WAIT: begin
        state_d = mcs_pkg::TOP_SORT;
      end
      mcs_pkg::TOP_SORT: begin
        if (sort_status.done) begin
          state_d = mcs_pkg::TOP_FINISH;
        end
      end
      mcs_pkg::TOP_FINISH: begin
        if (out_free) begin
          state_d = mcs_pkg::TOP_IDLE;
        end
      end
      default: state_d = mcs_pkg::TOP_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcs_pkg::TOP_IDLE;
      alpha_q     <= mcs_pkg::SYM_W'(mcs_pkg::MAX_SYMBOLS);
      last_q      <= '0;
      started_q   <= 1'b0;
      cnt_vld_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == mcs_pkg::TOP_FETCH);
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      if (in_xfer && (act == mcs_pkg::ACT_RESTART)) begin
        last_q    <= '0;
        started_q <= 1'b0;
        cnt_vld_q <= '0;
      end
      if (cnt_we) begin
        cnt_vld_q[sym_q] <= 1'b1;
        last_q           <= sym_q;
        started_q        <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      row_q  <= started_q ? last_q : mcs_pkg::SYM_W'(mcs_pkg::INIT_ROW);
      n_q    <= n_sym;
      draw_q <= in_i.random_draw;
      col_q  <= '0;
    end
    if (state_q == mcs_pkg::TOP_FETCH) begin
      col_q    <= col_q + 1'b1;
      rd_col_q <= col_q;
    end
    if (sort_status.done) begin
      hit_q <= sort_status.hit;
      sym_q <= sort_status.symbol;
    end
    if (finish) begin
      out_sym_q   <= hit_q ? sym_q : '0;
      out_nosel_q <= !hit_q;
      out_occ_q   <= hit_q ? cnt_new : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.symbol       = out_sym_q;
  assign out_o.no_selection = out_nosel_q;
  assign out_o.occupancy    = out_occ_q;

endmodule

[test/symbol_draw_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol draw monitor
// Watches the sampler channels and the alphabet size register. It keeps its
// own copy of the probability table and the chain state, predicts each drawn
// symbol and compares every output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module symbol_draw_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  mcs_in_if          in_mon,
  mcs_out_if         out_mon,
  output int         mismatch_count_o,
  output int         draws_pending_o,
  output int         draws_checked_o
);

  typedef struct packed {
    logic [mcs_pkg::SYM_W-1:0] symbol;
    logic                      no_selection;
    logic [mcs_pkg::CNT_W-1:0] occupancy;
  } draw_result_t;

  draw_result_t               expected_draws[$];
  logic [mcs_pkg::PROB_W-1:0] prob_tbl [mcs_pkg::TABLE_ROWS][mcs_pkg::MAX_SYMBOLS];
  logic [mcs_pkg::CNT_W-1:0]  occ_cnt [mcs_pkg::MAX_SYMBOLS];
  logic [mcs_pkg::SYM_W-1:0]  last_sym;
  logic                       started;
  logic [3:0]                 alphabet;

  assign draws_pending_o = expected_draws.size();

  task automatic report(input string what, input longint unsigned exp_v,
                        input longint unsigned got_v);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
    mismatch_count_o++;
  endtask

  // Exchange sort of the active row followed by the cumulative interval scan.
  task automatic draw_symbol(input logic [mcs_pkg::PROB_W-1:0] draw);
    logic [mcs_pkg::PROB_W-1:0] vals [mcs_pkg::MAX_SYMBOLS];
    int                         ids [mcs_pkg::MAX_SYMBOLS];
    logic [mcs_pkg::PROB_W-1:0] tv;
    int                         ti, n, row, hit;
    logic [31:0]                sum;
    draw_result_t               res;
    n   = (alphabet > mcs_pkg::MAX_SYMBOLS) ? mcs_pkg::MAX_SYMBOLS : alphabet;
    row = started ? int'(last_sym) : mcs_pkg::INIT_ROW;
    hit = -1;
    sum = '0;
    for (int i = 0; i < n; i++) begin
      vals[i] = prob_tbl[row][i];
      ids[i]  = i;
    end
    for (int i = 0; i < n; i++)
      for (int j = i; j < n; j++)
        if (vals[j] < vals[i]) begin
          tv = vals[i]; vals[i] = vals[j]; vals[j] = tv;
          ti = ids[i];  ids[i]  = ids[j];  ids[j]  = ti;
        end
    for (int i = 0; i < n; i++) begin
      if (hit < 0 && 32'(draw) >= sum && 32'(draw) <= sum + 32'(vals[i])) hit = ids[i];
      sum += 32'(vals[i]);
    end
    if (hit < 0) begin
      res = '{symbol: '0, no_selection: 1'b1, occupancy: '0};
    end else begin
      last_sym = mcs_pkg::SYM_W'(hit);
      started  = 1'b1;
      if (occ_cnt[hit] != '1) occ_cnt[hit]++;
      res = '{symbol: mcs_pkg::SYM_W'(hit), no_selection: 1'b0, occupancy: occ_cnt[hit]};
    end
    expected_draws.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    draw_result_t exp_r;
    if (!rst_ni) begin
      expected_draws.delete();
      for (int r = 0; r < mcs_pkg::TABLE_ROWS; r++)
        for (int c = 0; c < mcs_pkg::MAX_SYMBOLS; c++) prob_tbl[r][c] = '0;
      for (int c = 0; c < mcs_pkg::MAX_SYMBOLS; c++) occ_cnt[c] = '0;
      last_sym = '0;
      started  = 1'b0;
      alphabet = 4'd10;
      mismatch_count_o = 0;
      draws_checked_o  = 0;
    end else begin
      // The output side is handled first: a result never belongs to an item
      // accepted at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        draws_checked_o++;
        if (expected_draws.size() == 0) begin
          report("result with no draw pending", 0, out_mon.symbol);
        end else begin
          exp_r = expected_draws.pop_front();
          if (out_mon.symbol !== exp_r.symbol)
            report("symbol", exp_r.symbol, out_mon.symbol);
          if (out_mon.no_selection !== exp_r.no_selection)
            report("no_selection", exp_r.no_selection, out_mon.no_selection);
          if (out_mon.occupancy !== exp_r.occupancy)
            report("occupancy", exp_r.occupancy, out_mon.occupancy);
        end
      end
      if (cfg_we_i) alphabet = cfg_wdata_i;
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.action)
          mcs_pkg::ACT_WRITE: begin
            if (in_mon.table_row < mcs_pkg::TABLE_ROWS &&
                in_mon.table_column < mcs_pkg::MAX_SYMBOLS)
              prob_tbl[in_mon.table_row][in_mon.table_column] = in_mon.probability;
          end
          mcs_pkg::ACT_RESTART: begin
            for (int c = 0; c < mcs_pkg::MAX_SYMBOLS; c++) occ_cnt[c] = '0;
            last_sym = '0;
            started  = 1'b0;
          end
          mcs_pkg::ACT_GENERATE: draw_symbol(in_mon.random_draw);
          default: ;
        endcase
      end
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markov chain symbol sampler testbench
// Loads the probability table, steps the chain through directed corner cases
// and then a long random mix of row loads, draws, restarts and register
// changes, with bursty input traffic and a stalling receiver. Checking is done
// by the draw monitor; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SCALE       = 100000;
  // Settle time before a register write.
  localparam int SETTLE      = 120;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  mcs_in_if  in_ch ();
  mcs_out_if out_ch ();

  int mismatches, draws_pending, draws_checked;
  int items_sent, burst_left, cycles;
  int alph;
  logic hold_req;
  logic [15:0] sizes_seen;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  markov_chain_symbol_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  symbol_draw_monitor monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatch_count_o (mismatches),
    .draws_pending_o  (draws_pending),
    .draws_checked_o  (draws_checked)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver. It picks a new stall pattern at the start of each phase: always
  // ready, ready half of the time, or mostly stalled. Once asked, it holds off for a
  // long stretch so that the output register fills and the input backs up.
  initial begin
    int mode, phase, hold_cnt;
    logic hold_taken;
    mode = 0; phase = 0; hold_cnt = 0; hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_cnt   = 400;
      end
      if (phase == 0) mode = $urandom_range(0, 2);
      phase = (phase + 1) % 50;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One input transfer. The sender works in bursts; between bursts valid is
  // lowered for a random gap. Ready is looked at on the falling edge, where
  // it is settled, and the transfer completes at the following rising edge.
  task automatic push_item(input logic [1:0] act, input logic [3:0] row,
                           input logic [3:0] col, input logic [mcs_pkg::PROB_W-1:0] prob,
                           input logic [mcs_pkg::PROB_W-1:0] draw);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      // Now and then a long burst with no idling at all.
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.table_row    <= row;
    in_ch.table_column <= col;
    in_ch.probability  <= prob;
    in_ch.random_draw  <= draw;
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Pause the sender until every predicted result has been taken, then wait
  // a further settle time (callers give a nonzero one, so valid is never lowered
  // and raised in the same step).
  task automatic drain(input int extra);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (draws_pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_alphabet(input int size);
    drain(SETTLE);
    cfg_we    <= 1'b1;
    cfg_wdata <= 4'(size);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    alph = size;
    sizes_seen[size] = 1'b1;
  endtask

  function automatic int active_symbols();
    return (alph > mcs_pkg::MAX_SYMBOLS) ? mcs_pkg::MAX_SYMBOLS : alph;
  endfunction

  task automatic generate_draw(input logic [mcs_pkg::PROB_W-1:0] draw);
    push_item(mcs_pkg::ACT_GENERATE, 4'($urandom), 4'($urandom),
              mcs_pkg::PROB_W'($urandom), draw);
  endtask

  // Load a whole row. The first n entries form a distribution that sums to
  // the full scale, sometimes with equal entries to exercise tie ordering;
  // the unused columns get arbitrary values.
  task automatic load_row(input int row, input int n);
    int remaining, v, ties;
    remaining = SCALE;
    ties = ($urandom_range(0, 3) == 0);
    for (int c = 0; c < mcs_pkg::MAX_SYMBOLS; c++) begin
      if (c >= n) v = $urandom_range(0, SCALE);
      else if (c == n - 1) v = remaining;
      else if (ties) v = SCALE / n;
      else v = $urandom_range(0, remaining / 2);
      if (c < n) remaining -= v;
      push_item(mcs_pkg::ACT_WRITE, 4'(row), 4'(c), mcs_pkg::PROB_W'(v),
                mcs_pkg::PROB_W'($urandom));
    end
  endtask

  function automatic logic [mcs_pkg::PROB_W-1:0] pick_draw();
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) return '0;
    if (k < 8) return mcs_pkg::PROB_W'(SCALE);
    if (k < 13)
      return mcs_pkg::PROB_W'($urandom_range(SCALE + 1, (1 << mcs_pkg::PROB_W) - 1));
    return mcs_pkg::PROB_W'($urandom_range(0, SCALE));
  endfunction

  initial begin
    int kind;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 4'd0;
    hold_req    <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action       <= mcs_pkg::ACT_WRITE;
    in_ch.table_row    <= '0;
    in_ch.table_column <= '0;
    in_ch.probability  <= '0;
    in_ch.random_draw  <= '0;
    items_sent = 0;
    burst_left = 0;
    alph       = 10;
    sizes_seen = 16'h0400;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every entry is written before anything reads it.
    for (int r = 0; r < mcs_pkg::TABLE_ROWS; r++) load_row(r, mcs_pkg::MAX_SYMBOLS);

    // Directed part: draws at both ends of the scale and above it, an all-ones
    // entry, out of range writes, the unused action and a restart.
    generate_draw('0);
    generate_draw(mcs_pkg::PROB_W'(SCALE));
    generate_draw('1);
    push_item(mcs_pkg::ACT_WRITE, 4'(mcs_pkg::INIT_ROW), 4'd3, '1, '0);
    push_item(mcs_pkg::ACT_RESTART, '0, '0, '0, '1);
    generate_draw(mcs_pkg::PROB_W'(SCALE + 1));
    push_item(mcs_pkg::ACT_WRITE, 4'd11, 4'd0, '0, '0);
    push_item(mcs_pkg::ACT_WRITE, 4'd15, 4'd15, '1, '1);
    push_item(mcs_pkg::ACT_WRITE, 4'd2, 4'd10, '1, '0);
    push_item(2'd3, '1, '1, '1, '1);
    generate_draw(mcs_pkg::PROB_W'(SCALE / 2));
    load_row(mcs_pkg::INIT_ROW, mcs_pkg::MAX_SYMBOLS);
    push_item(mcs_pkg::ACT_RESTART, '0, '0, '0, '0);
    generate_draw(mcs_pkg::PROB_W'(SCALE / 3));
    // Register extremes: a single symbol, none at all and an oversized value.
    set_alphabet(1);
    generate_draw('0);
    generate_draw(mcs_pkg::PROB_W'(SCALE));
    set_alphabet(0);
    generate_draw('0);
    set_alphabet(15);
    generate_draw(pick_draw());
    set_alphabet(10);

    // Random part.
    while (items_sent < 1200) begin
      if (items_sent > 500 && !hold_req) begin
        hold_req <= 1'b1;
        repeat (30) generate_draw(pick_draw());
      end
      kind = $urandom_range(0, 99);
      if (kind < 58) generate_draw(pick_draw());
      else if (kind < 70) load_row($urandom_range(0, mcs_pkg::INIT_ROW), active_symbols());
      else if (kind < 78)
        push_item(mcs_pkg::ACT_WRITE, 4'($urandom), 4'($urandom),
                  mcs_pkg::PROB_W'($urandom), mcs_pkg::PROB_W'($urandom));
      else if (kind < 83) push_item(mcs_pkg::ACT_RESTART, 4'($urandom), 4'($urandom),
                                    mcs_pkg::PROB_W'($urandom), mcs_pkg::PROB_W'($urandom));
      else if (kind < 86) push_item(2'd3, 4'($urandom), 4'($urandom),
                                    mcs_pkg::PROB_W'($urandom), mcs_pkg::PROB_W'($urandom));
      else if (kind < 89) drain(1);
      else if (kind < 91)
        set_alphabet(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 10));
      else generate_draw(mcs_pkg::PROB_W'($urandom));
    end

    drain(SETTLE);
    $display("Covered %0d input transfers and %0d checked draws in %0d cycles,",
             items_sent, draws_checked, cycles);
    $display("with alphabet sizes seen (bit per size): %b", sizes_seen);
    if (mismatches == 0 && draws_pending == 0) begin
      $display("No mismatches found");
    end else begin
      if (draws_pending != 0) $display("%0d predicted draws never arrived", draws_pending);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/mcs_pkg.sv
sv/mcs_in_if.sv
sv/mcs_out_if.sv
sv/mcs_ram.sv
sv/mcs_sort_scan.sv
sv/markov_chain_symbol_sampler.sv
test/symbol_draw_monitor.sv
test/testbench.sv
